FILE: hw/rtl/murmur2_hash32_stream_core_assert.svh
// Assertion macros shared by the hash stream core modules.
// Each check samples on the rising clock edge and is off while reset is high.
`ifndef MURMUR2_HASH32_STREAM_CORE_ASSERT_SVH
`define MURMUR2_HASH32_STREAM_CORE_ASSERT_SVH
`ifndef SYNTH
// Plain property that must hold every cycle.
`define MH2S_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mh2s assertion failed");
// Same-cycle implication.
`define MH2S_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mh2s implication failed");
// Next-cycle implication.
`define MH2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mh2s next-cycle check failed");
`else
`define MH2S_ASSERT(label, clk, rst, prop)
`define MH2S_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MH2S_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/mh2s_pkg.sv
package mh2s_pkg;

   // Field widths
   localparam int WORD_W = 32;
   localparam int CNT_W  = 3;

   // MurmurHash2 constants
   localparam logic [WORD_W-1:0] MUR_MUL     = 32'h5bd1e995;
   localparam int                MUR_SHIFT   = 24;
   localparam int                FIN_SHIFT_A = 13;
   localparam int                FIN_SHIFT_B = 15;
   localparam logic [WORD_W-1:0] SEED_RESET  = 32'd97;
   localparam logic [CNT_W-1:0]  FULL_BYTES  = 3'd4;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item class decided by the front
   typedef enum logic [1:0] {
      ITEM_EMPTY,
      ITEM_FULL,
      ITEM_TAIL
   } mh2s_kind_type;

   // One queued transaction
   typedef struct packed {
      mh2s_kind_type     kind;
      logic [WORD_W-1:0] operand;    // mixed k for a full word, masked tail otherwise
      logic [CNT_W-1:0]  count;      // clamped byte count, 0 to 4
      logic              first;
      logic              last;
      logic [WORD_W-1:0] total;
   } mh2s_entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic empty;
      logic full;
   } mh2s_qstat_type;

   // Low 32 bits of a product with the mixing constant
   function automatic logic [WORD_W-1:0] mur_mul(input logic [WORD_W-1:0] a);
      logic [WORD_W-1:0] p;
      p = a * MUR_MUL;
      return p;
   endfunction

endpackage

FILE: hw/rtl/mh2s_req_if.sv
interface mh2s_req_if import mh2s_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic [CNT_W-1:0]  valid_bytes;
   logic              first_word;
   logic              last_word;
   logic [WORD_W-1:0] total_length;

   modport source (
      output valid, data_word, valid_bytes, first_word, last_word, total_length,
      input  ready
   );
   modport sink (
      input  valid, data_word, valid_bytes, first_word, last_word, total_length,
      output ready
   );
endinterface

FILE: hw/rtl/mh2s_rsp_if.sv
interface mh2s_rsp_if import mh2s_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_value;
   logic              length_error;

   modport source (
      output valid, hash_value, length_error,
      input  ready
   );
   modport sink (
      input  valid, hash_value, length_error,
      output ready
   );
endinterface

FILE: hw/rtl/murmur2_hash32_stream_core.sv
// Channel | Dir | Transaction
// req     | in  | data_word, valid_bytes, first_word, last_word, total_length
// rsp     | out | hash_value, length_error (one per last-marked transaction)
// csr     | in  | csr_wr_en / csr_wr_data write the hash seed (reset 97)
//
// Front: two-stage k-mix pipeline (one multiply per stage).
// Back: takes one queued transaction per cycle through the h multiply-XOR while
// in ST_RUN with the queue not empty; a last one also waits for a free output
// slot, then ST_FIN runs the finalizer multiply into the registered result.
// A 4-entry queue decouples front and back; rsp stalls back up through it.
// Reset is synchronous, active high; the hash state clears to zero.
module murmur2_hash32_stream_core import mh2s_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mh2s_req_if.sink          req,
   mh2s_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data
);

   logic           push;
   logic           pop;
   mh2s_entry_type push_entry;
   mh2s_entry_type head;
   mh2s_qstat_type q_stat;

   // Accept and classify, precompute the k-mix
   mh2s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   // Transaction queue
   mh2s_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // Running hash, length check and finalizer
   mh2s_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_stat      (q_stat),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp)
   );

endmodule

FILE: hw/rtl/mh2s_front.sv
module mh2s_front import mh2s_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   mh2s_req_if.sink       req,
   input  mh2s_qstat_type q_stat,
   output logic           push,
   output mh2s_entry_type push_entry
);

   mh2s_entry_type s1_ff, s1_in;
   mh2s_entry_type s2_ff, s2_in;
   logic           s1_valid_ff, s1_valid_in;
   logic           s2_valid_ff, s2_valid_in;
   logic           advance;
   logic [CNT_W-1:0]  cnt_clamp;
   logic [WORD_W-1:0] tail_mask;
   logic [WORD_W-1:0] k_fold;

   // Pipeline moves when the last stage is empty or can drain into the queue
   assign advance   = !s2_valid_ff || !q_stat.full;
   assign req.ready = advance;
   assign push       = s2_valid_ff && !q_stat.full;
   assign push_entry = s2_ff;

   // Classify: clamp the count, pick the mask for a tail
   always_comb begin
      cnt_clamp = (req.valid_bytes > FULL_BYTES) ? FULL_BYTES : req.valid_bytes;
      unique case (cnt_clamp)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = '0;
      endcase
   end

   // Stage 1: classify and take the first multiply of the k-mix
   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in   = req.valid;
         s1_in.count   = cnt_clamp;
         s1_in.first   = req.first_word;
         s1_in.last    = req.last_word;
         s1_in.total   = req.total_length;
         if (cnt_clamp == FULL_BYTES) begin
            s1_in.kind    = ITEM_FULL;
            s1_in.operand = mur_mul(req.data_word);
         end else if (cnt_clamp != '0) begin
            s1_in.kind    = ITEM_TAIL;
            s1_in.operand = req.data_word & tail_mask;
         end else begin
            s1_in.kind    = ITEM_EMPTY;
            s1_in.operand = '0;
         end
      end
   end

   // Stage 2: fold the top byte and take the second multiply
   assign k_fold = s1_ff.operand ^ (s1_ff.operand >> MUR_SHIFT);

   always_comb begin
      s2_in       = s2_ff;
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s2_valid_in = s1_valid_ff;
         s2_in       = s1_ff;
         if (s1_ff.kind == ITEM_FULL) begin
            s2_in.operand = mur_mul(k_fold);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

FILE: hw/rtl/mh2s_fifo.sv
`include "murmur2_hash32_stream_core_assert.svh"

module mh2s_fifo import mh2s_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mh2s_entry_type push_entry,
   input  logic           pop,
   output mh2s_entry_type head,
   output mh2s_qstat_type q_stat
);

   mh2s_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MH2S_ASSERT_IMPL(a_no_push_full, clock, reset, push, !q_stat.full)
   `MH2S_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, !q_stat.empty)
   `MH2S_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))

endmodule

FILE: hw/rtl/mh2s_back.sv
`include "murmur2_hash32_stream_core_assert.svh"

module mh2s_back import mh2s_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mh2s_entry_type    head,
   input  mh2s_qstat_type    q_stat,
   output logic              pop,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data,
   mh2s_rsp_if.source        rsp
);

   typedef enum logic {
      ST_RUN,
      ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] bytes_ff, bytes_in;
   logic [WORD_W-1:0] decl_ff, decl_in;
   logic              flag_ff, flag_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] fin_ff, fin_in;
   logic              err_ff, err_in;
   logic [WORD_W-1:0] h_base, b_base, d_base;
   logic              f_base;
   logic              out_free;

   // Output slot is free if empty or being taken this cycle
   assign out_free = !out_valid_ff || rsp.ready;

   // A last transaction needs the output slot for its finalizer step
   assign pop = (state_ff == ST_RUN) && !q_stat.empty && (!head.last || out_free);

   assign rsp.valid        = out_valid_ff;
   assign rsp.hash_value   = fin_ff ^ (fin_ff >> FIN_SHIFT_B);
   assign rsp.length_error = err_ff;

   // Starting point: a first transaction reloads from seed and length
   always_comb begin
      if (head.first) begin
         h_base = seed_ff ^ head.total;
         b_base = '0;
         d_base = head.total;
         f_base = 1'b0;
      end else begin
         h_base = hash_ff;
         b_base = bytes_ff;
         d_base = decl_ff;
         f_base = flag_ff;
      end
   end

   // Hash update, finalizer and output slot
   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      hash_in      = hash_ff;
      bytes_in     = bytes_ff;
      decl_in      = decl_ff;
      flag_in      = flag_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      fin_in       = fin_ff;
      err_in       = err_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (pop) begin
               case (head.kind)
                  ITEM_FULL: hash_in = mur_mul(h_base) ^ head.operand;
                  ITEM_TAIL: hash_in = mur_mul(h_base ^ head.operand);
                  default:   hash_in = h_base;
               endcase
               bytes_in = b_base + WORD_W'(head.count);
               decl_in  = d_base;
               flag_in  = f_base || ((head.kind == ITEM_TAIL) && !head.last);
               if (head.last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            fin_in       = mur_mul(hash_ff ^ (hash_ff >> FIN_SHIFT_A));
            err_in       = (bytes_ff != decl_ff) || flag_ff;
            out_valid_in = 1'b1;
            state_in     = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         seed_ff      <= SEED_RESET;
         hash_ff      <= '0;
         bytes_ff     <= '0;
         decl_ff      <= '0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         bytes_ff     <= bytes_in;
         decl_ff      <= decl_in;
         flag_ff      <= flag_in;
         out_valid_ff <= out_valid_in;
      end
      fin_ff <= fin_in;
      err_ff <= err_in;
   end

   `MH2S_ASSERT_IMPL(a_fin_slot_free, clock, reset, state_ff == ST_FIN, !out_valid_ff)
   `MH2S_ASSERT_NEXT(a_fin_shows_result, clock, reset, state_ff == ST_FIN, out_valid_ff)
   `MH2S_ASSERT_IMPL(a_no_pop_in_fin, clock, reset, state_ff == ST_FIN, !pop)

endmodule
